// File: src/ipv4fd_pkg.sv
// ----------------------------------------------------------------------------
// ipv4fd_pkg: shared types and codes
// Request and result items, request kinds, verdicts and register indexes.
// ----------------------------------------------------------------------------
package ipv4fd_pkg;

    localparam int ROUTE_DEPTH = 64;
    localparam int ARP_DEPTH   = 32;
    localparam int GROUP_SIZE  = 8;

    localparam logic [1:0] REQ_ROUTE = 2'd0;
    localparam logic [1:0] REQ_ARP   = 2'd1;
    localparam logic [1:0] REQ_FWD   = 2'd2;

    localparam logic [7:0] CFG_ROUTE_COUNT = 8'd0;
    localparam logic [7:0] CFG_ARP_COUNT   = 8'd1;

    typedef enum logic [2:0] {
        V_REPLY         = 3'd0,
        V_TIME_EXCEEDED = 3'd1,
        V_NO_ROUTE      = 3'd2,
        V_NO_ARP        = 3'd3,
        V_FORWARD       = 3'd4
    } t_verdict;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  entry_index;
        logic [31:0] entry_addr;
        logic [31:0] entry_mask;
        logic [31:0] entry_next_hop;
        logic [3:0]  entry_port;
        logic [47:0] entry_mac;
        logic [31:0] dest_ip;
        logic [31:0] local_ip;
        logic [7:0]  ttl_in;
        logic [15:0] checksum_in;
    } t_req;

    typedef struct packed {
        t_verdict    verdict;
        logic [3:0]  egress_port;
        logic [47:0] next_mac;
        logic [7:0]  ttl_out;
        logic [15:0] checksum_out;
    } t_res;

endpackage

// File: src/ipv4_forwarding_decision.sv
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision: IPv4 forwarding verdict pipeline
// Route and ARP tables, longest-prefix match, TTL and checksum update.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: an item is taken at a rising edge with start high and
//   busy low. busy is always low, so one item may enter every cycle.
//   Kinds: write route entry, write ARP entry, forward header.
//   Result: only forward items give a result, on o_res for one cycle with
//   o_done high, after the input register, route compare, group reduce,
//   final reduce, next-hop read, ARP compare, MAC pick and output stages.
//   Throughput: one item per cycle through the eight register stages.
//   Writes update each table field in the stage that reads it, so every
//   forward sees exactly the writes accepted before it.
//   Config: i_cfg_valid/o_cfg_ready (ready always high); index 0 route_count,
//   index 1 arp_count; write only while the pipeline is empty.
//   Reset: clears counts and stage valid bits; tables hold garbage until
//   written. The receiver cannot stall; results are never held.
module ipv4_forwarding_decision
    import ipv4fd_pkg::*;
#(
    parameter int ROUTE_ENTRIES = ROUTE_DEPTH,
    parameter int ARP_ENTRIES   = ARP_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_done,
    output t_res       o_res,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int RIW    = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int AIW    = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;
    localparam int GROUPS = (ROUTE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // config registers
    logic [6:0] r_route_count;
    logic [5:0] r_arp_count;

    // tables
    logic [31:0]    r_rt_prefix [ROUTE_ENTRIES];
    logic [31:0]    r_rt_mask   [ROUTE_ENTRIES];
    logic [31:0]    r_nh_mem    [ROUTE_ENTRIES];
    logic [3:0]     r_port_mem  [ROUTE_ENTRIES];
    logic [31:0]    r_arp_addr  [ARP_ENTRIES];
    logic [47:0]    r_arp_mac   [ARP_ENTRIES];

    // stage valid bits and carried items
    logic [6:0] r_v;
    t_req       r_p [7];

    // stage-specific payload
    logic              r_s1_hit  [ROUTE_ENTRIES];
    logic [31:0]       r_s1_mask [ROUTE_ENTRIES];
    logic              r_s2_gfound [GROUPS];
    logic [31:0]       r_s2_gmask  [GROUPS];
    logic [RIW-1:0]    r_s2_gidx   [GROUPS];
    logic              r_s3_found;
    logic [RIW-1:0]    r_s3_idx;
    logic              r_s4_found;
    logic [31:0]       r_s4_hop;
    logic [3:0]        r_s4_port;
    logic              r_s5_found;
    logic [3:0]        r_s5_port;
    logic              r_s5_ahit [ARP_ENTRIES];
    logic              r_s6_found;
    logic [3:0]        r_s6_port;
    logic              r_s6_arp;
    logic [47:0]       r_s6_mac;
    logic              r_done;
    t_res              r_res;

    // next values
    logic              n_s1_hit  [ROUTE_ENTRIES];
    logic              n_s2_gfound [GROUPS];
    logic [31:0]       n_s2_gmask  [GROUPS];
    logic [RIW-1:0]    n_s2_gidx   [GROUPS];
    logic              n_s3_found;
    logic [RIW-1:0]    n_s3_idx;
    logic              n_s5_ahit [ARP_ENTRIES];
    logic              n_s6_arp;
    logic [AIW-1:0]    n_s6_sel;
    t_res              n_res;
    logic [17:0]       n_sum0;
    logic [17:0]       n_sum1;
    logic [15:0]       n_sum2;

    logic w_rt_wr0, w_rt_wr3, w_arp_wr4, w_arp_wr5;
    assign w_rt_wr0  = r_v[0] && r_p[0].req_type == REQ_ROUTE
                       && int'(r_p[0].entry_index) < ROUTE_ENTRIES;
    assign w_rt_wr3  = r_v[3] && r_p[3].req_type == REQ_ROUTE
                       && int'(r_p[3].entry_index) < ROUTE_ENTRIES;
    assign w_arp_wr4 = r_v[4] && r_p[4].req_type == REQ_ARP
                       && int'(r_p[4].entry_index) < ARP_ENTRIES;
    assign w_arp_wr5 = r_v[5] && r_p[5].req_type == REQ_ARP
                       && int'(r_p[5].entry_index) < ARP_ENTRIES;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v           <= '0;
            r_done        <= 1'b0;
            r_route_count <= '0;
            r_arp_count   <= '0;
        end else begin
            r_v    <= {r_v[5:0], start && !busy};
            r_done <= r_v[6] && r_p[6].req_type == REQ_FWD;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROUTE_COUNT: r_route_count <= i_cfg_data[6:0];
                    CFG_ARP_COUNT:   r_arp_count   <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

    // stage 0 -> 1: compare dest against every route lane
    always_comb begin
        for (int i = 0; i < ROUTE_ENTRIES; i++) begin
            n_s1_hit[i] = (i < int'(r_route_count))
                && ((r_p[0].dest_ip & r_rt_mask[i]) == r_rt_prefix[i]);
        end
    end

    // stage 1 -> 2: best match inside each group of eight; ties keep lower index
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_s2_gfound[g] = 1'b0;
            n_s2_gmask[g]  = '0;
            n_s2_gidx[g]   = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (g * GROUP_SIZE + j < ROUTE_ENTRIES) begin
                    if (r_s1_hit[g * GROUP_SIZE + j] && (!n_s2_gfound[g]
                        || r_s1_mask[g * GROUP_SIZE + j] > n_s2_gmask[g])) begin
                        n_s2_gfound[g] = 1'b1;
                        n_s2_gmask[g]  = r_s1_mask[g * GROUP_SIZE + j];
                        n_s2_gidx[g]   = RIW'(g * GROUP_SIZE + j);
                    end
                end
            end
        end
    end

    // stage 2 -> 3: best over groups
    always_comb begin
        logic [31:0] best;
        best       = '0;
        n_s3_found = 1'b0;
        n_s3_idx   = '0;
        for (int g = 0; g < GROUPS; g++) begin
            if (r_s2_gfound[g] && (!n_s3_found || r_s2_gmask[g] > best)) begin
                n_s3_found = 1'b1;
                best       = r_s2_gmask[g];
                n_s3_idx   = r_s2_gidx[g];
            end
        end
    end

    // stage 4 -> 5: compare next hop against ARP lanes
    always_comb begin
        for (int i = 0; i < ARP_ENTRIES; i++) begin
            n_s5_ahit[i] = (i < int'(r_arp_count)) && (r_arp_addr[i] == r_s4_hop);
        end
    end

    // stage 5 -> 6: lowest matching ARP entry
    always_comb begin
        n_s6_arp = 1'b0;
        n_s6_sel = '0;
        for (int i = ARP_ENTRIES - 1; i >= 0; i--) begin
            if (r_s5_ahit[i]) begin
                n_s6_arp = 1'b1;
                n_s6_sel = AIW'(i);
            end
        end
    end

    // stage 6 -> out: verdict, TTL and RFC 1624 checksum update
    always_comb begin
        n_sum0 = {2'b00, ~r_p[6].checksum_in}
               + {2'b00, ~{r_p[6].ttl_in, 8'h00}}
               + {2'b00, r_p[6].ttl_in - 8'd1, 8'h00};
        n_sum1 = {2'b00, n_sum0[15:0]} + {16'd0, n_sum0[17:16]};
        n_sum2 = n_sum1[15:0] + {14'd0, n_sum1[17:16]};
        n_res  = '0;
        if (r_p[6].dest_ip == r_p[6].local_ip) begin
            n_res.verdict = V_REPLY;
        end else if (r_p[6].ttl_in <= 8'd1) begin
            n_res.verdict = V_TIME_EXCEEDED;
        end else if (!r_s6_found) begin
            n_res.verdict = V_NO_ROUTE;
        end else if (!r_s6_arp) begin
            n_res.verdict = V_NO_ARP;
        end else begin
            n_res.verdict      = V_FORWARD;
            n_res.egress_port  = r_s6_port;
            n_res.next_mac     = r_s6_mac;
            n_res.ttl_out      = r_p[6].ttl_in - 8'd1;
            n_res.checksum_out = ~n_sum2;
        end
    end

    // datapath registers and tables
    always_ff @(posedge i_clk) begin
        r_p[0] <= i_req;
        for (int k = 1; k < 7; k++) begin
            r_p[k] <= r_p[k-1];
        end

        // route prefix/mask: read and written at stage 0
        for (int i = 0; i < ROUTE_ENTRIES; i++) begin
            r_s1_hit[i]  <= n_s1_hit[i];
            r_s1_mask[i] <= r_rt_mask[i];
        end
        if (w_rt_wr0) begin
            r_rt_prefix[RIW'(r_p[0].entry_index)] <= r_p[0].entry_addr;
            r_rt_mask[RIW'(r_p[0].entry_index)]   <= r_p[0].entry_mask;
        end

        for (int g = 0; g < GROUPS; g++) begin
            r_s2_gfound[g] <= n_s2_gfound[g];
            r_s2_gmask[g]  <= n_s2_gmask[g];
            r_s2_gidx[g]   <= n_s2_gidx[g];
        end

        r_s3_found <= n_s3_found;
        r_s3_idx   <= n_s3_idx;

        // next hop / port memory: read and written at stage 3
        r_s4_found <= r_s3_found;
        r_s4_hop   <= r_nh_mem[r_s3_idx];
        r_s4_port  <= r_port_mem[r_s3_idx];
        if (w_rt_wr3) begin
            r_nh_mem[RIW'(r_p[3].entry_index)]   <= r_p[3].entry_next_hop;
            r_port_mem[RIW'(r_p[3].entry_index)] <= r_p[3].entry_port;
        end

        // ARP address lanes: read and written at stage 4
        r_s5_found <= r_s4_found;
        r_s5_port  <= r_s4_port;
        for (int i = 0; i < ARP_ENTRIES; i++) begin
            r_s5_ahit[i] <= n_s5_ahit[i];
        end
        if (w_arp_wr4) begin
            r_arp_addr[AIW'(r_p[4].entry_index)] <= r_p[4].entry_addr;
        end

        // ARP MAC: read and written at stage 5
        r_s6_found <= r_s5_found;
        r_s6_port  <= r_s5_port;
        r_s6_arp   <= n_s6_arp;
        r_s6_mac   <= r_arp_mac[n_s6_sel];
        if (w_arp_wr5) begin
            r_arp_mac[AIW'(r_p[5].entry_index)] <= r_p[5].entry_mac;
        end

        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    // assertions
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy && i_req.req_type == REQ_FWD, 8))
        else $error("result without a forward item eight cycles back");

    a_only_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[6] && r_p[6].req_type != REQ_FWD |=> !o_done)
        else $error("write item produced a result");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.verdict != V_FORWARD |->
            o_res.egress_port == 4'd0 && o_res.next_mac == 48'd0
            && o_res.ttl_out == 8'd0 && o_res.checksum_out == 16'd0)
        else $error("nonzero fields on a non-forward verdict");

    a_fwd_needs_arp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.verdict == V_FORWARD |-> $past(r_s6_arp && r_s6_found))
        else $error("forward without route and ARP hit");

endmodule
